>>> src/srma_pkg.sv
package srma_pkg;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_LOAD_FIRST  = 2'd0,
    REQ_LOAD_SECOND = 2'd1,
    REQ_END_ROW     = 2'd2
  } req_e;

  // Origin of a merged entry
  typedef enum logic [1:0] {
    SRC_BOTH   = 2'd0,
    SRC_FIRST  = 2'd1,
    SRC_SECOND = 2'd2
  } src_e;

  // Merge sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_SEND
  } state_e;

  localparam int unsigned ColW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CountW = 7;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [ColW-1:0]        col_index;
    logic signed [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ColW-1:0]        out_col;
    logic signed [ValW-1:0] out_value;
    logic [1:0]             source;
    logic                   last;
    logic [CountW-1:0]      merged_count;
    logic                   row_empty;
    logic                   overflow;
  } out_item_t;

  // Sequencer status seen by the load side
  typedef struct packed {
    logic idle;
    logic row_done;
  } status_t;

endpackage

>>> src/sparse_row_merge_add.sv
// Sparse row adder. Load items append a (column, value) pair to the list of
// operand one or operand two, ROW_CAP entries each, one load per cycle while
// idle; a load into a full list is dropped and the row is flagged overflow.
// An end-of-row item runs a two-pointer merge on one shared compare/add unit:
// a first pass counts the merged entries so that merged_count rides on every
// result, a second pass emits them in column order, one result per distinct
// head column (sum where both heads match, wrapping). The operand lists sit
// in memories with registered reads, so a counting step goes through a read
// and a compare state and an emitting step through read, compare and send
// states. An empty row returns its single flagged result in the cycle after
// the end-of-row item. in_ready_o is low from the end-of-row item until the
// last result of the row is taken. Counts and overflow clear then.

module sparse_row_merge_add #(
  parameter int unsigned ROW_CAP     = 32,
  parameter int unsigned INDEX_WIDTH = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srma_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srma_pkg::out_item_t out_item_o
);

  localparam int unsigned AddrW = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1;
  localparam int unsigned CntW  = $clog2(ROW_CAP + 1);
  localparam int unsigned NumW  = $clog2(2 * ROW_CAP + 1);

  logic                   in_acc;
  logic                   load_a, load_b, start;
  logic                   full_a, full_b;
  logic                   wr_a, wr_b;
  logic [CntW-1:0]        cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic                   ovf_q, ovf_d;
  logic [INDEX_WIDTH-1:0] wr_col;
  logic [VALUE_WIDTH-1:0] wr_val;
  logic [AddrW-1:0]       rd_addr_a, rd_addr_b;
  logic [INDEX_WIDTH-1:0] col_a, col_b;
  logic [VALUE_WIDTH-1:0] val_a, val_b;
  srma_pkg::status_t      status;

  assign in_ready_o = status.idle;
  assign in_acc     = in_valid_i && in_ready_o;

  // request decode
  always_comb begin
    load_a = 1'b0;
    load_b = 1'b0;
    start  = 1'b0;
    case (in_item_i.req_type)
      srma_pkg::REQ_LOAD_FIRST:  load_a = in_acc;
      srma_pkg::REQ_LOAD_SECOND: load_b = in_acc;
      srma_pkg::REQ_END_ROW:     start  = in_acc;
      default: begin
      end
    endcase
  end

  // column and value kept at the internal widths
  assign wr_col = INDEX_WIDTH'(in_item_i.col_index);
  assign wr_val = VALUE_WIDTH'(in_item_i.value);

  assign full_a = cnt_a_q == CntW'(ROW_CAP);
  assign full_b = cnt_b_q == CntW'(ROW_CAP);
  assign wr_a   = load_a && !full_a;
  assign wr_b   = load_b && !full_b;

  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    ovf_d   = ovf_q;
    if (status.row_done) begin
      cnt_a_d = '0;
      cnt_b_d = '0;
      ovf_d   = 1'b0;
    end else begin
      if (wr_a) begin
        cnt_a_d = cnt_a_q + CntW'(1);
      end
      if (wr_b) begin
        cnt_b_d = cnt_b_q + CntW'(1);
      end
      if ((load_a && full_a) || (load_b && full_b)) begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      ovf_q   <= ovf_d;
    end
  end

  srma_oplist #(
    .Depth (ROW_CAP),
    .AddrW (AddrW),
    .IdxW  (INDEX_WIDTH),
    .ValWd (VALUE_WIDTH)
  ) u_list_first (
    .clk_i     (clk_i),
    .wr_en_i   (wr_a),
    .wr_addr_i (cnt_a_q[AddrW-1:0]),
    .wr_col_i  (wr_col),
    .wr_val_i  (wr_val),
    .rd_addr_i (rd_addr_a),
    .rd_col_o  (col_a),
    .rd_val_o  (val_a)
  );

  srma_oplist #(
    .Depth (ROW_CAP),
    .AddrW (AddrW),
    .IdxW  (INDEX_WIDTH),
    .ValWd (VALUE_WIDTH)
  ) u_list_second (
    .clk_i     (clk_i),
    .wr_en_i   (wr_b),
    .wr_addr_i (cnt_b_q[AddrW-1:0]),
    .wr_col_i  (wr_col),
    .wr_val_i  (wr_val),
    .rd_addr_i (rd_addr_b),
    .rd_col_o  (col_b),
    .rd_val_o  (val_b)
  );

  srma_merge #(
    .AddrW (AddrW),
    .CntW  (CntW),
    .NumW  (NumW),
    .IdxW  (INDEX_WIDTH),
    .ValWd (VALUE_WIDTH)
  ) u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .cnt_first_i      (cnt_a_q),
    .cnt_second_i     (cnt_b_q),
    .ovf_i            (ovf_q),
    .rd_addr_first_o  (rd_addr_a),
    .rd_addr_second_o (rd_addr_b),
    .col_first_i      (col_a),
    .val_first_i      (val_a),
    .col_second_i     (col_b),
    .val_second_i     (val_b),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_item_o       (out_item_o),
    .status_o         (status)
  );

endmodule

>>> src/srma_oplist.sv
module srma_oplist #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5,
  parameter int unsigned IdxW  = 32,
  parameter int unsigned ValWd = 32
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [IdxW-1:0]  wr_col_i,
  input  logic [ValWd-1:0] wr_val_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [IdxW-1:0]  rd_col_o,
  output logic [ValWd-1:0] rd_val_o
);

  logic [IdxW-1:0]  col_mem [Depth];
  logic [ValWd-1:0] val_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      col_mem[wr_addr_i] <= wr_col_i;
      val_mem[wr_addr_i] <= wr_val_i;
    end
  end

  // registered read, one address per cycle
  always_ff @(posedge clk_i) begin
    rd_col_o <= col_mem[rd_addr_i];
    rd_val_o <= val_mem[rd_addr_i];
  end

endmodule

>>> src/srma_merge.sv
module srma_merge #(
  parameter int unsigned AddrW = 5,
  parameter int unsigned CntW  = 6,
  parameter int unsigned NumW  = 7,
  parameter int unsigned IdxW  = 32,
  parameter int unsigned ValWd = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CntW-1:0]     cnt_first_i,
  input  logic [CntW-1:0]     cnt_second_i,
  input  logic                ovf_i,
  output logic [AddrW-1:0]    rd_addr_first_o,
  output logic [AddrW-1:0]    rd_addr_second_o,
  input  logic [IdxW-1:0]     col_first_i,
  input  logic [ValWd-1:0]    val_first_i,
  input  logic [IdxW-1:0]     col_second_i,
  input  logic [ValWd-1:0]    val_second_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srma_pkg::out_item_t out_item_o,
  output srma_pkg::status_t   status_o
);

  srma_pkg::state_e    state_q, state_d;
  logic [CntW-1:0]     ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
  logic [NumW-1:0]     num_q, num_d;
  logic                emit_q, emit_d;
  srma_pkg::out_item_t out_q, out_d;

  logic             a_left, b_left, col_eq, col_lt;
  logic             take_a, take_b, fin;
  logic [CntW-1:0]  ptr_a_nx, ptr_b_nx;
  logic [ValWd-1:0] sum;
  logic [IdxW-1:0]  sel_col;
  logic [ValWd-1:0] sel_val;
  srma_pkg::src_e   sel_src;
  logic             row_empty;

  // shared compare and add unit
  always_comb begin
    a_left   = ptr_a_q < cnt_first_i;
    b_left   = ptr_b_q < cnt_second_i;
    col_eq   = col_first_i == col_second_i;
    col_lt   = col_first_i < col_second_i;
    take_a   = a_left && (!b_left || col_lt || col_eq);
    take_b   = b_left && (!a_left || !col_lt);
    ptr_a_nx = ptr_a_q + CntW'(take_a);
    ptr_b_nx = ptr_b_q + CntW'(take_b);
    fin      = (ptr_a_nx >= cnt_first_i) && (ptr_b_nx >= cnt_second_i);
    sum      = val_first_i + val_second_i;
    sel_col  = take_a ? col_first_i : col_second_i;
    if (take_a && take_b) begin
      sel_val = sum;
      sel_src = srma_pkg::SRC_BOTH;
    end else if (take_a) begin
      sel_val = val_first_i;
      sel_src = srma_pkg::SRC_FIRST;
    end else begin
      sel_val = val_second_i;
      sel_src = srma_pkg::SRC_SECOND;
    end
    row_empty = (cnt_first_i == '0) && (cnt_second_i == '0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srma_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = row_empty ? srma_pkg::ST_SEND : srma_pkg::ST_READ;
        end
      end
      srma_pkg::ST_READ: begin
        state_d = srma_pkg::ST_STEP;
      end
      srma_pkg::ST_STEP: begin
        state_d = emit_q ? srma_pkg::ST_SEND : srma_pkg::ST_READ;
      end
      srma_pkg::ST_SEND: begin
        if (out_ready_i) begin
          state_d = out_q.last ? srma_pkg::ST_IDLE : srma_pkg::ST_READ;
        end
      end
      default: state_d = srma_pkg::ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    ptr_a_d = ptr_a_q;
    ptr_b_d = ptr_b_q;
    num_d   = num_q;
    emit_d  = emit_q;
    out_d   = out_q;
    case (state_q)
      srma_pkg::ST_IDLE: begin
        if (start_i) begin
          ptr_a_d = '0;
          ptr_b_d = '0;
          num_d   = '0;
          emit_d  = 1'b0;
          out_d.out_col      = '0;
          out_d.out_value    = '0;
          out_d.source       = srma_pkg::SRC_BOTH;
          out_d.last         = 1'b1;
          out_d.merged_count = '0;
          out_d.row_empty    = 1'b1;
          out_d.overflow     = ovf_i;
        end
      end
      srma_pkg::ST_STEP: begin
        if (!emit_q) begin
          // count pass: walk the merge, tally results
          num_d = num_q + NumW'(1);
          if (fin) begin
            ptr_a_d = '0;
            ptr_b_d = '0;
            emit_d  = 1'b1;
          end else begin
            ptr_a_d = ptr_a_nx;
            ptr_b_d = ptr_b_nx;
          end
        end else begin
          ptr_a_d = ptr_a_nx;
          ptr_b_d = ptr_b_nx;
          out_d.out_col      = srma_pkg::ColW'(sel_col);
          out_d.out_value    = srma_pkg::ValW'(sel_val);
          out_d.source       = sel_src;
          out_d.last         = fin;
          out_d.merged_count = srma_pkg::CountW'(num_q);
          out_d.row_empty    = 1'b0;
          out_d.overflow     = ovf_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srma_pkg::ST_IDLE;
      ptr_a_q <= '0;
      ptr_b_q <= '0;
      num_q   <= '0;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_a_q <= ptr_a_d;
      ptr_b_q <= ptr_b_d;
      num_q   <= num_d;
      emit_q  <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // outputs
  always_comb begin
    rd_addr_first_o   = ptr_a_q[AddrW-1:0];
    rd_addr_second_o  = ptr_b_q[AddrW-1:0];
    out_valid_o       = state_q == srma_pkg::ST_SEND;
    out_item_o        = out_q;
    status_o.idle     = state_q == srma_pkg::ST_IDLE;
    status_o.row_done = (state_q == srma_pkg::ST_SEND) && out_ready_i && out_q.last;
  end

endmodule

>>> src/srma_checker.sv
module srma_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input srma_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input srma_pkg::out_item_t out_item_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // never open for input while a result is pending
  a_busy_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && in_ready_o))
    else $error("input ready while result pending");

  // end of row locks the input side
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.req_type == srma_pkg::REQ_END_ROW)
    |=> !in_ready_o)
    else $error("ready right after end of row");

  // more results of the row follow a non-final one
  a_row_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.last |=> !in_ready_o)
    else $error("row ended without last");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.row_empty
    |-> out_item_o.last && (out_item_o.merged_count == '0))
    else $error("malformed empty-row result");

endmodule

bind sparse_row_merge_add srma_checker u_srma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
